// ===== rtl/bmfm_pkg.sv =====
// Shared types and constants for the binary matrix from margins block.
`default_nettype none

package bmfm_pkg;

  // Field widths fixed by the item format
  localparam int MODE_W    = 2;
  localparam int POS_W     = 5;
  localparam int AMT_W     = 6;
  localparam int ROW_IDX_W = 5;
  localparam int MASK_W    = 32;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  // Count registers after reset
  localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 6'd32;
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 6'd32;

  // Item operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ROW   = 2'd0,
    MODE_COL   = 2'd1,
    MODE_SOLVE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Control from the sequencer to the max-select unit
  typedef struct packed {
    logic clear;
    logic sample;
    logic excluded;
  } scan_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/bmfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bmfm_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bmfm_scan.sv =====
// Shared max-select unit: tracks the largest eligible remaining column demand.
`default_nettype none

module bmfm_scan #(
  parameter int COL_AW = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bmfm_pkg::scan_ctrl_t          ctrl,
  input  wire logic [COL_AW-1:0]             idx,
  input  wire logic [bmfm_pkg::AMT_W-1:0]    data,
  output logic                               found,
  output logic      [COL_AW-1:0]             best,
  output logic      [bmfm_pkg::AMT_W-1:0]    best_val
);

  import bmfm_pkg::*;

  logic take;

  // Strictly greater wins, so ties stay at the lowest column
  assign take = ctrl.sample && !ctrl.excluded && (data != '0) &&
                (!found || (data > best_val));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  // Hold the current leader
  always_ff @(posedge clk) begin
    if (take && !ctrl.clear) begin
      best     <= idx;
      best_val <= data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/binary_matrix_from_margins_core.sv =====
// Top level: demand loading, sum check, greedy row fill and mask emission.
// Load items (row or column demand) write the demand stores; unused mode items are ignored.
// Solve: a sum check over max(R,C) entries, then per row a demand read and load, one
// scan per one placed (one column read per cycle via the compare unit), then a mask write.
// Results: mask read, load, hold until taken; a failed solve emits one result right away.
// The block takes no new item until every result of a solve is delivered.
// Synchronous active-high reset: idle, counts at 32; demand stores undefined until loaded.
`default_nettype none

module binary_matrix_from_margins_core #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bmfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bmfm_pkg::CFG_W-1:0]        cfg_data,
  // Input items
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bmfm_pkg::MODE_W-1:0]       mode,
  input  wire logic [bmfm_pkg::POS_W-1:0]        position,
  input  wire logic [bmfm_pkg::AMT_W-1:0]        amount,
  // Result items
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [bmfm_pkg::ROW_IDX_W-1:0]    row_index,
  output logic      [bmfm_pkg::MASK_W-1:0]       column_mask,
  output logic                                   possible,
  output logic                                   last
);

  import bmfm_pkg::*;

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int MAX_RC = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int CNT_W  = $clog2(MAX_RC + 1);
  localparam int DIFF_W = $clog2(MAX_RC * ((1 << AMT_W) - 1) + 1) + 1;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_SUM       = 12'b0000_0000_0010,
    S_SUM_END   = 12'b0000_0000_0100,
    S_ROW_RD    = 12'b0000_0000_1000,
    S_ROW_LD    = 12'b0000_0001_0000,
    S_SCAN      = 12'b0000_0010_0000,
    S_SCAN_END  = 12'b0000_0100_0000,
    S_PICK      = 12'b0000_1000_0000,
    S_ROW_WR    = 12'b0001_0000_0000,
    S_EMIT_RD   = 12'b0010_0000_0000,
    S_EMIT_LD   = 12'b0100_0000_0000,
    S_EMIT_WAIT = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0]  row_count, column_count;
  logic [CNT_W-1:0]  row_lim, col_lim, row_last, col_last, sum_last;

  logic [CNT_W-1:0]  i, k, j;
  logic [AMT_W-1:0]  need, pick;
  logic [MAX_COLS-1:0] mask, pick_bit;
  logic signed [DIFF_W-1:0] diff, diff_next;

  // Sum pass pipeline tags
  logic              s_vld, s_rv, s_cv;
  logic [CNT_W-1:0]  s_k;
  // Scan pipeline tags
  logic              sc_vld;
  logic [COL_AW-1:0] sc_idx;

  logic              in_acc, fail;
  mode_t             mode_in;

  // Memory ports
  logic              row_we, col_we, rem_we, msk_we;
  logic [ROW_AW-1:0] row_waddr, row_raddr, msk_addr;
  logic [COL_AW-1:0] col_waddr, rem_waddr;
  logic [AMT_W-1:0]  rem_wdata;
  logic [AMT_W-1:0]  row_rdata, col_rdata, rem_rdata;
  logic [MAX_COLS-1:0] msk_rdata;

  // Compare unit
  scan_ctrl_t        scan_ctrl;
  logic              scan_found;
  logic [COL_AW-1:0] scan_best;
  logic [AMT_W-1:0]  scan_best_val;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign mode_in   = mode_t'(mode);

  // Clamp the counts into 1..MAX
  assign row_lim = (row_count == '0) ? CNT_W'(1) :
                   ((32'(row_count) > 32'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(row_count));
  assign col_lim = (column_count == '0) ? CNT_W'(1) :
                   ((32'(column_count) > 32'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                         : CNT_W'(column_count));
  assign row_last = row_lim - CNT_W'(1);
  assign col_last = col_lim - CNT_W'(1);
  assign sum_last = ((row_lim > col_lim) ? row_lim : col_lim) - CNT_W'(1);

  // Running row-minus-column sum difference
  assign diff_next = diff + (s_rv ? DIFF_W'(row_rdata) : DIFF_W'(0))
                          - (s_cv ? DIFF_W'(col_rdata) : DIFF_W'(0));

  assign pick_bit = MAX_COLS'(1) << scan_best;

  assign fail = ((state == S_SUM_END) && (diff_next != '0)) ||
                ((state == S_PICK) && !scan_found);

  // Load writes from input items
  always_comb begin
    row_we    = 1'b0;
    col_we    = 1'b0;
    row_waddr = ROW_AW'(position);
    col_waddr = COL_AW'(position);
    if (in_acc) begin
      unique case (mode_in)
        MODE_ROW:   row_we = (32'(position) < 32'(MAX_ROWS));
        MODE_COL:   col_we = (32'(position) < 32'(MAX_COLS));
        MODE_SOLVE: row_we = 1'b0;
        MODE_NONE:  col_we = 1'b0;
      endcase
    end
  end

  // Read addresses and working-copy writes
  always_comb begin
    row_raddr = (state == S_SUM) ? k[ROW_AW-1:0] : i[ROW_AW-1:0];
    msk_addr  = i[ROW_AW-1:0];
    msk_we    = (state == S_ROW_WR);
    if (state == S_PICK) begin
      rem_we    = scan_found;
      rem_waddr = scan_best;
      rem_wdata = scan_best_val - AMT_W'(1);
    end else begin
      rem_we    = s_vld && s_cv;
      rem_waddr = s_k[COL_AW-1:0];
      rem_wdata = col_rdata;
    end
  end

  always_comb begin
    scan_ctrl.clear    = (state == S_ROW_LD) || (state == S_PICK);
    scan_ctrl.sample   = sc_vld;
    scan_ctrl.excluded = mask[sc_idx];
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_acc && (mode_in == MODE_SOLVE)) state_next = S_SUM;
      S_SUM:       if (k == sum_last) state_next = S_SUM_END;
      S_SUM_END:   state_next = fail ? S_EMIT_WAIT : S_ROW_RD;
      S_ROW_RD:    state_next = S_ROW_LD;
      S_ROW_LD:    state_next = (row_rdata == '0) ? S_ROW_WR : S_SCAN;
      S_SCAN:      if (j == col_last) state_next = S_SCAN_END;
      S_SCAN_END:  state_next = S_PICK;
      S_PICK: begin
        if (!scan_found) begin
          state_next = S_EMIT_WAIT;
        end else if (pick == (need - AMT_W'(1))) begin
          state_next = S_ROW_WR;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_ROW_WR:    state_next = (i == row_last) ? S_EMIT_RD : S_ROW_RD;
      S_EMIT_RD:   state_next = S_EMIT_LD;
      S_EMIT_LD:   state_next = S_EMIT_WAIT;
      S_EMIT_WAIT: if (!out_stall) state_next = last ? S_IDLE : S_EMIT_RD;
      default:     state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      row_count    <= ROW_COUNT_RESET;
      column_count <= COLUMN_COUNT_RESET;
      s_vld        <= 1'b0;
      sc_vld       <= 1'b0;
    end else begin
      state  <= state_next;
      s_vld  <= (state == S_SUM);
      sc_vld <= (state == S_SCAN);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROW_COUNT:    row_count    <= cfg_data;
          REG_COLUMN_COUNT: column_count <= cfg_data;
        endcase
      end
      if (fail || (state == S_EMIT_LD)) begin
        out_valid <= 1'b1;
      end else if ((state == S_EMIT_WAIT) && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Counters, working mask and pipeline tags
  always_ff @(posedge clk) begin
    s_k    <= k;
    s_rv   <= (k < row_lim);
    s_cv   <= (k < col_lim);
    sc_idx <= j[COL_AW-1:0];
    if (state == S_IDLE) begin
      diff <= '0;
    end else if (s_vld) begin
      diff <= diff_next;
    end
    unique case (state)
      S_IDLE:     k <= '0;
      S_SUM:      k <= k + CNT_W'(1);
      S_SUM_END:  i <= '0;
      S_ROW_LD: begin
        need <= row_rdata;
        pick <= '0;
        mask <= '0;
        j    <= '0;
      end
      S_SCAN:     j <= j + CNT_W'(1);
      S_PICK: begin
        mask <= mask | pick_bit;
        pick <= pick + AMT_W'(1);
        j    <= '0;
      end
      S_ROW_WR:   i <= (i == row_last) ? '0 : (i + CNT_W'(1));
      S_EMIT_WAIT: if (!out_stall && !last) i <= i + CNT_W'(1);
      default:    ;
    endcase
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fail) begin
      row_index   <= '0;
      column_mask <= '0;
      possible    <= 1'b0;
      last        <= 1'b1;
    end else if (state == S_EMIT_LD) begin
      row_index   <= ROW_IDX_W'(i);
      column_mask <= MASK_W'(msk_rdata);
      possible    <= 1'b1;
      last        <= (i == row_last);
    end
  end

  bmfm_ram #(.WIDTH(AMT_W), .DEPTH(MAX_ROWS)) u_row_dem (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (amount),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  bmfm_ram #(.WIDTH(AMT_W), .DEPTH(MAX_COLS)) u_col_dem (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (amount),
    .raddr (k[COL_AW-1:0]),
    .rdata (col_rdata)
  );

  bmfm_ram #(.WIDTH(AMT_W), .DEPTH(MAX_COLS)) u_remain (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (j[COL_AW-1:0]),
    .rdata (rem_rdata)
  );

  bmfm_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_masks (
    .clk   (clk),
    .we    (msk_we),
    .waddr (msk_addr),
    .wdata (mask),
    .raddr (msk_addr),
    .rdata (msk_rdata)
  );

  bmfm_scan #(.COL_AW(COL_AW)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (scan_ctrl),
    .idx      (sc_idx),
    .data     (rem_rdata),
    .found    (scan_found),
    .best     (scan_best),
    .best_val (scan_best_val)
  );

  // No new item while a result is pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("item accepted while a result is pending");

  // An impossible result is the lone, zeroed, final one
  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !possible) |-> (last && (column_mask == '0) && (row_index == '0)))
    else $error("malformed impossible result");

  // A solve item starts the sequencer
  a_solve_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (mode_in == MODE_SOLVE)) |=> in_stall)
    else $error("solve item did not start a run");

  // A chosen column is new to this row and still has demand
  a_pick_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PICK) && scan_found) |-> ((scan_best_val != '0) && !mask[scan_best]))
    else $error("greedy pick chose a used or empty column");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state lost its one-hot code");

endmodule

`default_nettype wire
